>>> sv/olt_pkg.sv
// ----------------------------------------------------------------------------
// olt_pkg
// Shared types and constants for the order lifecycle table.
// ----------------------------------------------------------------------------
package olt_pkg;

	localparam int MAX_ORDERS = 4096;
	localparam int SEEN_DEPTH = 256;

	localparam int ADDR_W  = $clog2(MAX_ORDERS);
	localparam int NEXT_W  = ADDR_W + 1;
	localparam int SEEN_AW = $clog2(SEEN_DEPTH);
	localparam int SEEN_CW = SEEN_AW + 1;

	localparam logic [2:0] OP_SUBMIT  = 3'd0;
	localparam logic [2:0] OP_ACCEPT  = 3'd1;
	localparam logic [2:0] OP_REJECT  = 3'd2;
	localparam logic [2:0] OP_CANCEL  = 3'd3;
	localparam logic [2:0] OP_REPLACE = 3'd4;
	localparam logic [2:0] OP_FILL    = 3'd5;
	localparam logic [2:0] OP_QUERY   = 3'd6;

	localparam logic [2:0] ST_NONE   = 3'd0;
	localparam logic [2:0] ST_ACC    = 3'd1;
	localparam logic [2:0] ST_REJ    = 3'd2;
	localparam logic [2:0] ST_PART   = 3'd3;
	localparam logic [2:0] ST_FILLED = 3'd4;
	localparam logic [2:0] ST_CANC   = 3'd5;

	typedef struct packed {
		logic needs_tag;
		logic fill_neg;
	} cls_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [11:0] target_id;
		logic [15:0] symbol;
		logic        side;
		logic [1:0]  order_kind;
		logic [31:0] price;
		logic [30:0] quantity;
		logic        risk_accepted;
		logic [63:0] exec_tag;
		logic [30:0] fill_mag;
		cls_t        cls;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] symbol;
		logic        side;
		logic [1:0]  kind;
		logic [31:0] price;
		logic [30:0] quantity;
		logic [30:0] filled;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> sv/olt_ram.sv
// ----------------------------------------------------------------------------
// olt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module olt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/olt_front.sv
// ----------------------------------------------------------------------------
// olt_front
// Input side: accept beats, classify them and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module olt_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  olt_pkg::item_t in_item,
	input  logic          exec_id_valid,
	input  logic          fill_sign,
	output logic          head_valid,
	output olt_pkg::item_t head,
	input  logic          pop
);

	olt_pkg::item_t ent_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;
	olt_pkg::item_t cls_item;
	logic           push;

	always_comb begin
		cls_item = in_item;
		cls_item.cls.needs_tag = (in_item.op == olt_pkg::OP_FILL) && exec_id_valid;
		cls_item.cls.fill_neg  = fill_sign;
	end

	assign in_ready   = (cnt_q != 2'd2);
	assign push       = in_valid && in_ready;
	assign head_valid = (cnt_q != 2'd0);
	assign head       = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= cls_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

>>> sv/olt_back.sv
// ----------------------------------------------------------------------------
// olt_back
// Execution side: order table read-modify-write, seen tag walk, result register.
// ----------------------------------------------------------------------------
module olt_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  olt_pkg::item_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           ok,
	output logic [11:0]    result_id,
	output logic [2:0]     status,
	output logic [15:0]    out_symbol,
	output logic           out_side,
	output logic [1:0]     out_kind,
	output logic [31:0]    out_price,
	output logic [30:0]    out_quantity,
	output logic [30:0]    filled_total,
	output logic           release_risk,
	output logic [30:0]    risk_fill_qty,
	output logic [11:0]    live_orders
);

	localparam logic [3:0] S_CLR    = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_RD     = 4'd2;
	localparam logic [3:0] S_EVAL   = 4'd3;
	localparam logic [3:0] S_SRD    = 4'd4;
	localparam logic [3:0] S_SCMP   = 4'd5;
	localparam logic [3:0] S_FILL   = 4'd6;
	localparam logic [3:0] S_WR     = 4'd7;
	localparam logic [3:0] S_WR_NEW = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;

	logic [3:0]                  state_q;
	logic [olt_pkg::ADDR_W-1:0]  clr_q;
	olt_pkg::item_t              cur_q;
	olt_pkg::entry_t             rep_q;
	logic [11:0]                 rep_id_q;
	logic                        ok_q;
	logic                        show_q;
	logic                        rel_q;
	logic                        new_q;
	logic [30:0]                 take_q;
	logic [olt_pkg::SEEN_CW-1:0] idx_q;
	logic [olt_pkg::SEEN_CW-1:0] seen_cnt_q;
	logic [olt_pkg::NEXT_W-1:0]  next_id_q;

	logic                        o_we;
	logic [olt_pkg::ADDR_W-1:0]  o_waddr;
	olt_pkg::entry_t             o_wdata;
	olt_pkg::entry_t             o_rdata;
	logic                        s_we;
	logic [63:0]                 s_rdata;

	olt_pkg::entry_t             new_ent;
	logic                        full;
	logic                        tid_ok;
	logic                        found;
	logic                        live;
	logic [30:0]                 rem;
	logic [30:0]                 take;
	logic [30:0]                 f_sum;

	olt_pkg::entry_t             ev_ent;
	logic                        ev_ok;
	logic                        ev_rel;
	logic                        ev_new;
	logic                        ev_show;
	olt_pkg::entry_t             fill_ent;

	olt_ram #(.WIDTH(olt_pkg::ENTRY_W), .DEPTH(olt_pkg::MAX_ORDERS)) u_order_ram (
		.clk   (clk),
		.we    (o_we),
		.waddr (o_waddr),
		.wdata (o_wdata),
		.raddr (olt_pkg::ADDR_W'(cur_q.target_id)),
		.rdata (o_rdata)
	);

	olt_ram #(.WIDTH(64), .DEPTH(olt_pkg::SEEN_DEPTH)) u_seen_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (seen_cnt_q[olt_pkg::SEEN_AW-1:0]),
		.wdata (cur_q.exec_tag),
		.raddr (idx_q[olt_pkg::SEEN_AW-1:0]),
		.rdata (s_rdata)
	);

	always_comb begin
		new_ent.status   = cur_q.risk_accepted ? olt_pkg::ST_ACC : olt_pkg::ST_REJ;
		new_ent.symbol   = cur_q.symbol;
		new_ent.side     = cur_q.side;
		new_ent.kind     = cur_q.order_kind;
		new_ent.price    = cur_q.price;
		new_ent.quantity = cur_q.quantity;
		new_ent.filled   = '0;
	end

	assign full   = (next_id_q >= olt_pkg::NEXT_W'(olt_pkg::MAX_ORDERS));
	assign tid_ok = (cur_q.target_id != 12'd0) &&
		({1'b0, cur_q.target_id} < 13'(olt_pkg::MAX_ORDERS));
	assign found  = tid_ok && (o_rdata.status != olt_pkg::ST_NONE);
	assign live   = found && ((o_rdata.status == olt_pkg::ST_ACC) ||
		(o_rdata.status == olt_pkg::ST_PART));

	assign rem   = (rep_q.quantity > rep_q.filled) ? (rep_q.quantity - rep_q.filled) : '0;
	assign take  = (cur_q.fill_mag > rem) ? rem : cur_q.fill_mag;
	assign f_sum = rep_q.filled + take;

	always_comb begin
		ev_ent  = o_rdata;
		ev_ok   = 1'b0;
		ev_rel  = 1'b0;
		ev_new  = 1'b0;
		ev_show = found;
		case (cur_q.op)
			olt_pkg::OP_SUBMIT: begin
				ev_ok = !full;
			end
			olt_pkg::OP_ACCEPT: begin
				ev_ok         = found;
				ev_ent.status = olt_pkg::ST_ACC;
			end
			olt_pkg::OP_REJECT: begin
				ev_ok         = found;
				ev_rel        = live;
				ev_ent.status = olt_pkg::ST_REJ;
			end
			olt_pkg::OP_CANCEL: begin
				ev_ok  = live;
				ev_rel = live;
				if (live) begin
					ev_ent.status = olt_pkg::ST_CANC;
				end
			end
			olt_pkg::OP_REPLACE: begin
				ev_ok  = live && !full;
				ev_rel = live && !full;
				ev_new = live && !full;
				if (live && !full) begin
					ev_ent.status = olt_pkg::ST_CANC;
				end
			end
			olt_pkg::OP_QUERY: begin
				ev_ok = found;
			end
			olt_pkg::OP_FILL: begin
			end
			default: begin
				ev_show = 1'b0;
			end
		endcase
	end

	always_comb begin
		fill_ent        = rep_q;
		fill_ent.filled = f_sum;
		fill_ent.status = (f_sum >= rep_q.quantity) ? olt_pkg::ST_FILLED : olt_pkg::ST_PART;
	end

	assign pop = (state_q == S_IDLE) && head_valid;
	assign s_we = (state_q == S_SRD) && (idx_q == seen_cnt_q) &&
		(seen_cnt_q < olt_pkg::SEEN_CW'(olt_pkg::SEEN_DEPTH));

	always_comb begin
		o_we    = 1'b0;
		o_waddr = olt_pkg::ADDR_W'(rep_id_q);
		o_wdata = rep_q;
		unique case (state_q)
			S_CLR: begin
				o_we    = 1'b1;
				o_waddr = clr_q;
				o_wdata = '0;
			end
			S_WR: begin
				o_we = 1'b1;
			end
			S_WR_NEW: begin
				o_we    = 1'b1;
				o_waddr = olt_pkg::ADDR_W'(next_id_q);
				o_wdata = new_ent;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (head_valid) begin
					cur_q <= head;
				end
			end
			S_EVAL: begin
				rep_q    <= ev_ent;
				rep_id_q <= cur_q.target_id;
				show_q   <= ev_show;
				ok_q     <= ev_ok;
				rel_q    <= ev_rel;
				new_q    <= ev_new;
				take_q   <= '0;
				idx_q    <= '0;
			end
			S_SCMP: begin
				idx_q <= idx_q + olt_pkg::SEEN_CW'(1);
			end
			S_FILL: begin
				if (take != '0) begin
					ok_q   <= 1'b1;
					take_q <= take;
					rep_q  <= fill_ent;
				end
			end
			S_WR_NEW: begin
				rep_q    <= new_ent;
				rep_id_q <= 12'(next_id_q);
				show_q   <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_q      <= '0;
			seen_cnt_q <= '0;
			next_id_q  <= olt_pkg::NEXT_W'(1);
			out_valid  <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + olt_pkg::ADDR_W'(1);
					if (clr_q == olt_pkg::ADDR_W'(olt_pkg::MAX_ORDERS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (head_valid) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					case (cur_q.op)
						olt_pkg::OP_SUBMIT: begin
							state_q <= full ? S_DONE : S_WR_NEW;
						end
						olt_pkg::OP_ACCEPT, olt_pkg::OP_REJECT: begin
							state_q <= found ? S_WR : S_DONE;
						end
						olt_pkg::OP_CANCEL: begin
							state_q <= live ? S_WR : S_DONE;
						end
						olt_pkg::OP_REPLACE: begin
							state_q <= (live && !full) ? S_WR : S_DONE;
						end
						olt_pkg::OP_FILL: begin
							if (!live) begin
								state_q <= S_DONE;
							end else if (cur_q.cls.needs_tag) begin
								state_q <= S_SRD;
							end else begin
								state_q <= cur_q.cls.fill_neg ? S_DONE : S_FILL;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_SRD: begin
					if (idx_q == seen_cnt_q) begin
						if (s_we) begin
							seen_cnt_q <= seen_cnt_q + olt_pkg::SEEN_CW'(1);
							state_q    <= cur_q.cls.fill_neg ? S_DONE : S_FILL;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						state_q <= S_SCMP;
					end
				end
				S_SCMP: begin
					state_q <= (s_rdata == cur_q.exec_tag) ? S_DONE : S_SRD;
				end
				S_FILL: begin
					state_q <= (take != '0) ? S_WR : S_DONE;
				end
				S_WR: begin
					state_q <= new_q ? S_WR_NEW : S_DONE;
				end
				S_WR_NEW: begin
					next_id_q <= next_id_q + olt_pkg::NEXT_W'(1);
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && (!out_valid || out_ready)) begin
			ok            <= ok_q;
			result_id     <= show_q ? rep_id_q : '0;
			status        <= show_q ? rep_q.status : olt_pkg::ST_NONE;
			out_symbol    <= show_q ? rep_q.symbol : '0;
			out_side      <= show_q && rep_q.side;
			out_kind      <= show_q ? rep_q.kind : '0;
			out_price     <= show_q ? rep_q.price : '0;
			out_quantity  <= show_q ? rep_q.quantity : '0;
			filled_total  <= show_q ? rep_q.filled : '0;
			release_risk  <= rel_q;
			risk_fill_qty <= take_q;
			live_orders   <= 12'(next_id_q - olt_pkg::NEXT_W'(1));
		end
	end

endmodule

>>> sv/order_lifecycle_table.sv
// ----------------------------------------------------------------------------
// order_lifecycle_table
// Order table with submit, accept, reject, cancel, replace, fill and query.
//
//   channel | signals                              | direction
//   in      | in_valid/in_ready, op .. fill_amount | consumer
//   out     | out_valid/out_ready, ok .. live_orders | producer
//
// A fill with an execution id first compares its tag with each stored
// tag, walked through the seen RAM, before the fill is applied.
// The order RAM port bounds each item: one read and up to two writes.
// After reset a clearing pass zeroes every order RAM entry; beats are
// held in the two-entry queue meanwhile. Out stalls hold the back end only.
// ----------------------------------------------------------------------------
module order_lifecycle_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [11:0] target_id,
	input  logic [15:0] symbol,
	input  logic        side,
	input  logic [1:0]  order_kind,
	input  logic [31:0] price,
	input  logic [30:0] quantity,
	input  logic        risk_accepted,
	input  logic        exec_id_valid,
	input  logic [63:0] exec_tag,
	input  logic signed [31:0] fill_amount,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic [11:0] result_id,
	output logic [2:0]  status,
	output logic [15:0] out_symbol,
	output logic        out_side,
	output logic [1:0]  out_kind,
	output logic [31:0] out_price,
	output logic [30:0] out_quantity,
	output logic [30:0] filled_total,
	output logic        release_risk,
	output logic [30:0] risk_fill_qty,
	output logic [11:0] live_orders
);

	olt_pkg::item_t in_item;
	olt_pkg::item_t head;
	logic           head_valid;
	logic           pop;

	always_comb begin
		in_item.op            = op;
		in_item.target_id     = target_id;
		in_item.symbol        = symbol;
		in_item.side          = side;
		in_item.order_kind    = order_kind;
		in_item.price         = price;
		in_item.quantity      = quantity;
		in_item.risk_accepted = risk_accepted;
		in_item.exec_tag      = exec_tag;
		in_item.fill_mag      = fill_amount[30:0];
		in_item.cls           = '0;
	end

	olt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_item       (in_item),
		.exec_id_valid (exec_id_valid),
		.fill_sign     (fill_amount[31]),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop)
	);

	olt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.ok            (ok),
		.result_id     (result_id),
		.status        (status),
		.out_symbol    (out_symbol),
		.out_side      (out_side),
		.out_kind      (out_kind),
		.out_price     (out_price),
		.out_quantity  (out_quantity),
		.filled_total  (filled_total),
		.release_risk  (release_risk),
		.risk_fill_qty (risk_fill_qty),
		.live_orders   (live_orders)
	);

endmodule

>>> test/order_lifecycle_table_test.sv
// ----------------------------------------------------------------------------
// order_lifecycle_table_test
// Self-checking bench for the order table: a queue-fed driver offers beats
// in bursts, a mirror of the table predicts each result on acceptance, and
// a monitor compares every output beat field by field. Covers directed
// corner cases and a long random mix of lifecycles with repeated tags.
// ----------------------------------------------------------------------------
module order_lifecycle_table_test;

	typedef struct {
		logic [2:0]  op;
		logic [11:0] target_id;
		logic [15:0] symbol;
		logic        side;
		logic [1:0]  order_kind;
		logic [31:0] price;
		logic [30:0] quantity;
		logic        risk_accepted;
		logic        exec_id_valid;
		logic [63:0] exec_tag;
		logic [31:0] fill_amount;
		logic        wait_drain;
	} beat_t;

	typedef struct {
		logic        ok;
		logic [11:0] result_id;
		logic [2:0]  status;
		logic [15:0] symbol;
		logic        side;
		logic [1:0]  kind;
		logic [31:0] price;
		logic [30:0] quantity;
		logic [30:0] filled;
		logic        release_risk;
		logic [30:0] risk_fill_qty;
		logic [11:0] live_orders;
	} outcome_t;

	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] op = '0;
	logic [11:0] target_id = '0;
	logic [15:0] symbol = '0;
	logic side = 1'b0;
	logic [1:0] order_kind = '0;
	logic [31:0] price = '0;
	logic [30:0] quantity = '0;
	logic risk_accepted = 1'b0;
	logic exec_id_valid = 1'b0;
	logic [63:0] exec_tag = '0;
	logic signed [31:0] fill_amount = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic ok;
	logic [11:0] result_id;
	logic [2:0] status;
	logic [15:0] out_symbol;
	logic out_side;
	logic [1:0] out_kind;
	logic [31:0] out_price;
	logic [30:0] out_quantity;
	logic [30:0] filled_total;
	logic release_risk;
	logic [30:0] risk_fill_qty;
	logic [11:0] live_orders;

	order_lifecycle_table u_top (.*);

	// order table mirror
	logic [12:0] next_id = 13'd1;
	logic [2:0]  st_tab [olt_pkg::MAX_ORDERS];
	logic [15:0] sym_tab [olt_pkg::MAX_ORDERS];
	logic        side_tab [olt_pkg::MAX_ORDERS];
	logic [1:0]  kind_tab [olt_pkg::MAX_ORDERS];
	logic [31:0] price_tab [olt_pkg::MAX_ORDERS];
	logic [30:0] qty_tab [olt_pkg::MAX_ORDERS];
	logic [30:0] filled_tab [olt_pkg::MAX_ORDERS];
	logic [63:0] seen_tags [$];

	beat_t    pending [$];
	outcome_t awaited [$];
	logic [63:0] used_tags [$];
	int gen_hi = 0;
	int err_count = 0;
	int beats_in = 0;
	int idle_cycles = 0;
	logic in_fired = 1'b0;
	int burst_left = 8;
	int gap_left = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;
	int cyc = 0;

	initial begin
		for (int i = 0; i < olt_pkg::MAX_ORDERS; i++)
			st_tab[i] = olt_pkg::ST_NONE;
	end

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic order_live(logic [2:0] s);
		return s == olt_pkg::ST_ACC || s == olt_pkg::ST_PART;
	endfunction

	function automatic logic [11:0] store_order(beat_t b);
		logic [11:0] id;
		id = next_id[11:0];
		sym_tab[id] = b.symbol;
		side_tab[id] = b.side;
		kind_tab[id] = b.order_kind;
		price_tab[id] = b.price;
		qty_tab[id] = b.quantity;
		filled_tab[id] = '0;
		st_tab[id] = b.risk_accepted ? olt_pkg::ST_ACC : olt_pkg::ST_REJ;
		next_id = next_id + 13'd1;
		return id;
	endfunction

	function automatic outcome_t apply_beat(beat_t b);
		outcome_t r;
		logic full, found, show, drop;
		logic [11:0] id;
		logic [30:0] amt, rem, take, f;
		r = '{default: '0};
		full = next_id >= olt_pkg::MAX_ORDERS;
		id = b.target_id;
		found = id != 0 && st_tab[id] != olt_pkg::ST_NONE;
		show = found;
		case (b.op)
			olt_pkg::OP_SUBMIT: begin
				if (!full) begin
					id = store_order(b);
					show = 1'b1;
					r.ok = 1'b1;
				end
			end
			olt_pkg::OP_ACCEPT: begin
				if (found) begin
					st_tab[id] = olt_pkg::ST_ACC;
					r.ok = 1'b1;
				end
			end
			olt_pkg::OP_REJECT: begin
				if (found) begin
					r.release_risk = order_live(st_tab[id]);
					st_tab[id] = olt_pkg::ST_REJ;
					r.ok = 1'b1;
				end
			end
			olt_pkg::OP_CANCEL: begin
				if (found && order_live(st_tab[id])) begin
					st_tab[id] = olt_pkg::ST_CANC;
					r.release_risk = 1'b1;
					r.ok = 1'b1;
				end
			end
			olt_pkg::OP_REPLACE: begin
				if (found && !full && order_live(st_tab[id])) begin
					st_tab[id] = olt_pkg::ST_CANC;
					r.release_risk = 1'b1;
					id = store_order(b);
					r.ok = 1'b1;
				end
			end
			olt_pkg::OP_FILL: begin
				if (found && order_live(st_tab[id])) begin
					drop = 1'b0;
					if (b.exec_id_valid) begin
						foreach (seen_tags[i])
							if (seen_tags[i] == b.exec_tag)
								drop = 1'b1;
						if (!drop) begin
							if (seen_tags.size() >= olt_pkg::SEEN_DEPTH)
								drop = 1'b1;
							else
								seen_tags.push_back(b.exec_tag);
						end
					end
					if (!drop && !b.fill_amount[31]) begin
						amt = b.fill_amount[30:0];
						f = filled_tab[id];
						rem = qty_tab[id] > f ? qty_tab[id] - f : '0;
						take = amt > rem ? rem : amt;
						if (take != 0) begin
							f = f + take;
							filled_tab[id] = f;
							st_tab[id] = f >= qty_tab[id] ? olt_pkg::ST_FILLED : olt_pkg::ST_PART;
							r.risk_fill_qty = take;
							r.ok = 1'b1;
						end
					end
				end
			end
			olt_pkg::OP_QUERY: r.ok = found;
			default: show = 1'b0;
		endcase
		if (show) begin
			r.result_id = id;
			r.status = st_tab[id];
			r.symbol = sym_tab[id];
			r.side = side_tab[id];
			r.kind = kind_tab[id];
			r.price = price_tab[id];
			r.quantity = qty_tab[id];
			r.filled = filled_tab[id];
		end
		r.live_orders = next_id[11:0] - 12'd1;
		return r;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			err_count++;
		end
	endtask

	// stimulus construction
	function automatic beat_t mk(logic [2:0] o, logic [11:0] id);
		beat_t b;
		b.op = o;
		b.target_id = id;
		b.symbol = 16'($urandom);
		b.side = 1'($urandom);
		b.order_kind = 2'($urandom);
		b.price = $urandom;
		b.quantity = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(1, 200));
		b.risk_accepted = $urandom_range(0, 5) != 0;
		b.exec_id_valid = $urandom_range(0, 9) < 7;
		b.exec_tag = {$urandom, $urandom};
		b.fill_amount = $urandom_range(0, 120);
		b.wait_drain = 1'b0;
		return b;
	endfunction

	function automatic logic [11:0] pick_id();
		int lo;
		if (gen_hi == 0 || $urandom_range(0, 9) == 0)
			return 12'($urandom);
		if ($urandom_range(0, 9) < 6) begin
			lo = gen_hi > 16 ? gen_hi - 15 : 1;
			return 12'($urandom_range(lo, gen_hi));
		end
		return 12'($urandom_range(1, gen_hi));
	endfunction

	function automatic beat_t random_beat();
		beat_t b;
		int k;
		k = $urandom_range(0, 99);
		if (k < 25) b = mk(olt_pkg::OP_SUBMIT, 12'($urandom));
		else if (k < 34) b = mk(olt_pkg::OP_ACCEPT, pick_id());
		else if (k < 39) b = mk(olt_pkg::OP_REJECT, pick_id());
		else if (k < 47) b = mk(olt_pkg::OP_CANCEL, pick_id());
		else if (k < 55) b = mk(olt_pkg::OP_REPLACE, pick_id());
		else if (k < 88) b = mk(olt_pkg::OP_FILL, pick_id());
		else if (k < 98) b = mk(olt_pkg::OP_QUERY, pick_id());
		else b = mk(3'd7, pick_id());
		if (b.op == olt_pkg::OP_SUBMIT || b.op == olt_pkg::OP_REPLACE)
			gen_hi++;
		if (b.exec_id_valid && used_tags.size() > 0 && $urandom_range(0, 3) == 0)
			b.exec_tag = used_tags[$urandom_range(0, used_tags.size() - 1)];
		else
			used_tags.push_back(b.exec_tag);
		k = $urandom_range(0, 19);
		if (k < 2)
			b.fill_amount = {1'b1, 31'($urandom)};
		else if (k == 2)
			b.fill_amount = $urandom;
		return b;
	endfunction

	task automatic add(beat_t b);
		if (b.op == olt_pkg::OP_SUBMIT || b.op == olt_pkg::OP_REPLACE)
			gen_hi++;
		pending.push_back(b);
	endtask

	task automatic build_stimulus();
		beat_t b;
		// directed: ids 1.. are created in order
		b = mk(olt_pkg::OP_SUBMIT, '0);
		b.symbol = '1; b.side = 1'b1; b.order_kind = '1; b.price = '1;
		b.quantity = '1; b.risk_accepted = 1'b1;
		add(b);
		b = mk(olt_pkg::OP_SUBMIT, '1);
		b.symbol = '0; b.side = 1'b0; b.order_kind = '0; b.price = '0;
		b.quantity = 31'd10; b.risk_accepted = 1'b0;
		add(b);
		add(mk(olt_pkg::OP_QUERY, 12'd0));
		add(mk(olt_pkg::OP_QUERY, 12'd4095));
		add(mk(olt_pkg::OP_ACCEPT, 12'd4000));
		add(mk(olt_pkg::OP_ACCEPT, 12'd2));
		b = mk(olt_pkg::OP_FILL, 12'd1);
		b.exec_id_valid = 1'b1; b.exec_tag = '1; b.fill_amount = 32'h7fff_ffff;
		add(b);
		b = mk(olt_pkg::OP_SUBMIT, '0);
		b.quantity = 31'd50; b.risk_accepted = 1'b1;
		add(b);
		b = mk(olt_pkg::OP_FILL, 12'd3);
		b.exec_id_valid = 1'b1; b.exec_tag = '1; b.fill_amount = 32'd5;
		add(b);
		b = mk(olt_pkg::OP_FILL, 12'd3);
		b.exec_id_valid = 1'b1; b.exec_tag = '0; b.fill_amount = 32'd0;
		add(b);
		b = mk(olt_pkg::OP_FILL, 12'd3);
		b.exec_id_valid = 1'b0; b.fill_amount = 32'h8000_0000;
		add(b);
		b = mk(olt_pkg::OP_FILL, 12'd3);
		b.exec_id_valid = 1'b0; b.fill_amount = 32'd20;
		add(b);
		b = mk(olt_pkg::OP_FILL, 12'd3);
		b.exec_id_valid = 1'b0; b.fill_amount = 32'd100;
		add(b);
		add(mk(olt_pkg::OP_FILL, 12'd3));
		add(mk(olt_pkg::OP_CANCEL, 12'd3));
		add(mk(olt_pkg::OP_ACCEPT, 12'd3));
		add(mk(olt_pkg::OP_CANCEL, 12'd3));
		add(mk(olt_pkg::OP_CANCEL, 12'd3));
		add(mk(olt_pkg::OP_REJECT, 12'd3));
		add(mk(olt_pkg::OP_REJECT, 12'd3));
		b = mk(olt_pkg::OP_REPLACE, 12'd2);
		b.risk_accepted = 1'b1;
		add(b);
		add(mk(olt_pkg::OP_REPLACE, 12'd2));
		add(mk(3'd7, 12'd4));
		add(mk(olt_pkg::OP_QUERY, 12'd4));
		for (int i = 0; i < 1525; i++) begin
			b = random_beat();
			b.wait_drain = (i == 800);
			pending.push_back(b);
		end
	endtask

	task automatic drive(beat_t b);
		in_valid <= 1'b1;
		op <= b.op;
		target_id <= b.target_id;
		symbol <= b.symbol;
		side <= b.side;
		order_kind <= b.order_kind;
		price <= b.price;
		quantity <= b.quantity;
		risk_accepted <= b.risk_accepted;
		exec_id_valid <= b.exec_id_valid;
		exec_tag <= b.exec_tag;
		fill_amount <= b.fill_amount;
	endtask

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_fired) begin
		end else if (gap_left > 0) begin
			gap_left--;
			in_valid <= 1'b0;
		end else if (pending.size() > 0 && !(pending[0].wait_drain && awaited.size() > 0)) begin
			drive(pending.pop_front());
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 24);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver
	always @(negedge clk) begin
		cyc++;
		if (!hold_done && beats_in >= 700) begin
			hold_done = 1'b1;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case ((cyc / 1500) % 3)
				0: out_ready <= 1'b1;
				1: out_ready <= $urandom_range(0, 9) < 7;
				default: out_ready <= (cyc % 7) != 3 && (cyc % 5) != 0;
			endcase
		end
	end

	// predict on input beats, check output beats
	always @(posedge clk) begin
		outcome_t w;
		beat_t b;
		in_fired <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			b.op = op; b.target_id = target_id; b.symbol = symbol; b.side = side;
			b.order_kind = order_kind; b.price = price; b.quantity = quantity;
			b.risk_accepted = risk_accepted; b.exec_id_valid = exec_id_valid;
			b.exec_tag = exec_tag; b.fill_amount = fill_amount; b.wait_drain = 1'b0;
			awaited.push_back(apply_beat(b));
			beats_in++;
		end
		if (out_valid && out_ready) begin
			if (awaited.size() == 0) begin
				$error("result beat with nothing awaited");
				err_count++;
			end else begin
				w = awaited.pop_front();
				check_field("ok", w.ok, ok);
				check_field("result_id", w.result_id, result_id);
				check_field("status", w.status, status);
				check_field("out_symbol", w.symbol, out_symbol);
				check_field("out_side", w.side, out_side);
				check_field("out_kind", w.kind, out_kind);
				check_field("out_price", w.price, out_price);
				check_field("out_quantity", w.quantity, out_quantity);
				check_field("filled_total", w.filled, filled_total);
				check_field("release_risk", w.release_risk, release_risk);
				check_field("risk_fill_qty", w.risk_fill_qty, risk_fill_qty);
				check_field("live_orders", w.live_orders, live_orders);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		build_stimulus();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (pending.size() > 0 || in_valid || awaited.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (err_count == 0 && awaited.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
